// ===== src/char_lcd_refresh_sequencer_top_assert.svh =====
// Assertion macros shared by the LCD refresh sequencer RTL.
`ifndef CHAR_LCD_REFRESH_SEQUENCER_TOP_ASSERT_SVH
`define CHAR_LCD_REFRESH_SEQUENCER_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is held.
`define CLRS_ASSERT_IMPLY(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("sequencer check failed");

// Next-cycle implication, disabled while reset is held.
`define CLRS_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("sequencer check failed");

`endif

// ===== src/clrs_pkg.sv =====
// Types and constants of the character LCD refresh sequencer.
`timescale 1ns / 1ps

package clrs_pkg;

    localparam int LINE_LENGTH = 16;
    localparam int BUF_SIZE    = 2 * LINE_LENGTH;
    localparam int BUF_AW      = $clog2(BUF_SIZE);
    localparam int INIT_STEPS  = 6;
    localparam int INIT_AW     = $clog2(INIT_STEPS);
    localparam int STEP_W      = $clog2(LINE_LENGTH);

    localparam int POS_W   = 5;
    localparam int CHAR_W  = 8;
    localparam int DELAY_W = 16;
    localparam int CFG_AW  = 2;

    localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CMD_HOME   = 8'h80;
    localparam logic [CHAR_W-1:0] CMD_LINE2  = 8'hC0;

    localparam logic [CHAR_W-1:0] INIT_SEQ [INIT_STEPS] =
        '{8'h03, 8'h03, 8'h03, 8'h38, 8'h0C, 8'h06};

    localparam logic [DELAY_W-1:0] INIT_DELAY_RST = 16'd400;
    localparam logic [DELAY_W-1:0] CHAR_DELAY_RST = 16'd25;

    // configuration register indexes
    localparam logic [CFG_AW-1:0] CFG_INIT_DELAY   = 2'd0;
    localparam logic [CFG_AW-1:0] CFG_CHAR_DELAY   = 2'd1;
    localparam logic [CFG_AW-1:0] CFG_BACKLIGHT_ON = 2'd2;

    // sequencer phases
    localparam int PH_W = 4;
    localparam logic [PH_W-1:0] PH_START     = 4'd0;
    localparam logic [PH_W-1:0] PH_INIT      = 4'd1;
    localparam logic [PH_W-1:0] PH_INIT_WAIT = 4'd2;
    localparam logic [PH_W-1:0] PH_HOME      = 4'd3;
    localparam logic [PH_W-1:0] PH_TOP       = 4'd4;
    localparam logic [PH_W-1:0] PH_TOP_WAIT  = 4'd5;
    localparam logic [PH_W-1:0] PH_LINE2     = 4'd6;
    localparam logic [PH_W-1:0] PH_BOT       = 4'd7;
    localparam logic [PH_W-1:0] PH_BOT_WAIT  = 4'd8;

    // what the sequencer puts out for the current tick
    typedef struct packed {
        logic              xfer;
        logic              rs;
        logic              from_buf;
        logic [CHAR_W-1:0] instr;
        logic [BUF_AW-1:0] rd_idx;
    } cmd_t;

endpackage

// ===== src/clrs_fbuf.sv =====
// Frame buffer: one write port, one combinational read port, resets to spaces.
`timescale 1ns / 1ps

module clrs_fbuf (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         wr_en,
    input  logic [clrs_pkg::POS_W-1:0]   wr_pos,
    input  logic [clrs_pkg::CHAR_W-1:0]  wr_char,
    input  logic [clrs_pkg::BUF_AW-1:0]  rd_idx,
    output logic [clrs_pkg::CHAR_W-1:0]  rd_data
);

    localparam int CMP_W = ((clrs_pkg::BUF_AW > clrs_pkg::POS_W) ?
                            clrs_pkg::BUF_AW : clrs_pkg::POS_W) + 1;

    logic [clrs_pkg::CHAR_W-1:0] buf_reg [clrs_pkg::BUF_SIZE];
    logic [CMP_W-1:0]            pos_ext;
    logic                        pos_ok;

    assign pos_ext = CMP_W'(wr_pos);
    // drop writes past the end of the buffer
    assign pos_ok  = pos_ext < CMP_W'(clrs_pkg::BUF_SIZE);
    assign rd_data = buf_reg[rd_idx];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < clrs_pkg::BUF_SIZE; i++) begin
                buf_reg[i] <= clrs_pkg::CHAR_SPACE;
            end
        end else if (wr_en && pos_ok) begin
            buf_reg[pos_ext[clrs_pkg::BUF_AW-1:0]] <= wr_char;
        end
    end

endmodule

// ===== src/clrs_fsm.sv =====
// Refresh sequencer: init instructions, then endless line refresh with tick delays.
`timescale 1ns / 1ps

module clrs_fsm (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          tick_en,
    input  logic [clrs_pkg::DELAY_W-1:0]  init_delay,
    input  logic [clrs_pkg::DELAY_W-1:0]  char_delay,
    output clrs_pkg::cmd_t                cmd
);

    logic [clrs_pkg::PH_W-1:0]    phase_reg, phase_next;
    logic [clrs_pkg::STEP_W-1:0]  step_reg, step_next;
    logic [clrs_pkg::DELAY_W-1:0] wait_reg, wait_next;

    logic                         xfer_done;
    logic                         step_adv;
    logic [clrs_pkg::DELAY_W-1:0] delay_sel;
    logic [clrs_pkg::PH_W-1:0]    wait_ph;
    logic [clrs_pkg::STEP_W:0]    step_inc;
    logic [clrs_pkg::CHAR_W-1:0]  init_byte;

    assign step_inc = {1'b0, step_reg} + (clrs_pkg::STEP_W + 1)'(1);

    always_comb begin
        if (step_reg < clrs_pkg::STEP_W'(clrs_pkg::INIT_STEPS)) begin
            init_byte = clrs_pkg::INIT_SEQ[step_reg[clrs_pkg::INIT_AW-1:0]];
        end else begin
            init_byte = clrs_pkg::INIT_SEQ[0];
        end
    end

    always_comb begin
        cmd        = '0;
        phase_next = phase_reg;
        step_next  = step_reg;
        wait_next  = wait_reg;
        xfer_done  = 1'b0;
        step_adv   = 1'b0;
        delay_sel  = init_delay;
        wait_ph    = clrs_pkg::PH_INIT_WAIT;

        unique case (phase_reg) inside
            clrs_pkg::PH_INIT: begin
                cmd.xfer  = 1'b1;
                cmd.instr = init_byte;
                xfer_done = 1'b1;
            end
            clrs_pkg::PH_HOME: begin
                cmd.xfer   = 1'b1;
                cmd.instr  = clrs_pkg::CMD_HOME;
                step_next  = '0;
                phase_next = clrs_pkg::PH_TOP;
            end
            clrs_pkg::PH_TOP: begin
                cmd.xfer     = 1'b1;
                cmd.rs       = 1'b1;
                cmd.from_buf = 1'b1;
                cmd.rd_idx   = clrs_pkg::BUF_AW'(step_reg);
                xfer_done    = 1'b1;
                delay_sel    = char_delay;
                wait_ph      = clrs_pkg::PH_TOP_WAIT;
            end
            clrs_pkg::PH_LINE2: begin
                cmd.xfer   = 1'b1;
                cmd.instr  = clrs_pkg::CMD_LINE2;
                step_next  = '0;
                phase_next = clrs_pkg::PH_BOT;
            end
            clrs_pkg::PH_BOT: begin
                cmd.xfer     = 1'b1;
                cmd.rs       = 1'b1;
                cmd.from_buf = 1'b1;
                cmd.rd_idx   = clrs_pkg::BUF_AW'(clrs_pkg::LINE_LENGTH)
                             + clrs_pkg::BUF_AW'(step_reg);
                xfer_done    = 1'b1;
                delay_sel    = char_delay;
                wait_ph      = clrs_pkg::PH_BOT_WAIT;
            end
            clrs_pkg::PH_INIT_WAIT, clrs_pkg::PH_TOP_WAIT, clrs_pkg::PH_BOT_WAIT: begin
                wait_ph = phase_reg;
                if (wait_reg > clrs_pkg::DELAY_W'(1)) begin
                    wait_next = wait_reg - clrs_pkg::DELAY_W'(1);
                end else begin
                    step_adv = 1'b1;
                end
            end
            default: begin
                step_next  = '0;
                wait_next  = '0;
                phase_next = clrs_pkg::PH_INIT;
            end
        endcase

        // a nonzero delay parks in the wait phase, zero moves on at once
        if (xfer_done && (delay_sel != '0)) begin
            wait_next  = delay_sel;
            phase_next = wait_ph;
        end else if (xfer_done || step_adv) begin
            wait_next = '0;
            case (wait_ph)
                clrs_pkg::PH_INIT_WAIT: begin
                    if (step_inc >= (clrs_pkg::STEP_W + 1)'(clrs_pkg::INIT_STEPS)) begin
                        step_next  = '0;
                        phase_next = clrs_pkg::PH_HOME;
                    end else begin
                        step_next  = step_inc[clrs_pkg::STEP_W-1:0];
                        phase_next = clrs_pkg::PH_INIT;
                    end
                end
                clrs_pkg::PH_TOP_WAIT: begin
                    if (step_inc >= (clrs_pkg::STEP_W + 1)'(clrs_pkg::LINE_LENGTH)) begin
                        step_next  = '0;
                        phase_next = clrs_pkg::PH_LINE2;
                    end else begin
                        step_next  = step_inc[clrs_pkg::STEP_W-1:0];
                        phase_next = clrs_pkg::PH_TOP;
                    end
                end
                default: begin
                    if (step_inc >= (clrs_pkg::STEP_W + 1)'(clrs_pkg::LINE_LENGTH)) begin
                        step_next  = '0;
                        phase_next = clrs_pkg::PH_HOME;
                    end else begin
                        step_next  = step_inc[clrs_pkg::STEP_W-1:0];
                        phase_next = clrs_pkg::PH_BOT;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= clrs_pkg::PH_START;
            step_reg  <= '0;
            wait_reg  <= '0;
        end else if (tick_en) begin
            phase_reg <= phase_next;
            step_reg  <= step_next;
            wait_reg  <= wait_next;
        end
    end

endmodule

// ===== src/char_lcd_refresh_sequencer_top.sv =====
// Path: an accepted word waits in the input register, then moves into the result
// register when the result stage can take it; a stalled receiver holds it there.
// Throughput: one word per cycle while m_tready stays high; the input register, the
// sequencer and frame buffer update, and the result register work on words in turn.
// Reset (aresetn low, synchronous): sequencer to its start tick, frame buffer to
// spaces, delays to 400 and 25 ticks, backlight on, both stages emptied.
`timescale 1ns / 1ps

`include "char_lcd_refresh_sequencer_top_assert.svh"

module char_lcd_refresh_sequencer_top (
    input  logic                          aclk,
    input  logic                          aresetn,

    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [15:0]                   s_tdata,   // position[4:0], char_code[12:5]
    input  logic                          s_tuser,   // mode

    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [15:0]                   m_tdata,   // xfer_valid[0], data_byte[8:1], backlight[9]
    output logic                          m_tuser,   // reg_select

    input  logic                          cfg_wr_en,
    input  logic [clrs_pkg::CFG_AW-1:0]   cfg_addr,
    input  logic [clrs_pkg::DELAY_W-1:0]  cfg_wdata
);

    logic                          in_valid_reg;
    logic                          in_mode_reg;
    logic [clrs_pkg::POS_W-1:0]    in_pos_reg;
    logic [clrs_pkg::CHAR_W-1:0]   in_char_reg;

    logic                          out_valid_reg;
    logic                          out_xfer_reg;
    logic                          out_rs_reg;
    logic [clrs_pkg::CHAR_W-1:0]   out_byte_reg;
    logic                          out_bl_reg;

    logic [clrs_pkg::DELAY_W-1:0]  init_delay_reg;
    logic [clrs_pkg::DELAY_W-1:0]  char_delay_reg;
    logic                          backlight_on_reg;

    logic                          advance;
    logic                          tick_en;
    logic                          wr_en;
    clrs_pkg::cmd_t                cmd;
    logic [clrs_pkg::CHAR_W-1:0]   buf_data;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign tick_en  = advance && !in_mode_reg;
    assign wr_en    = advance && in_mode_reg;

    clrs_fsm u_fsm (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .tick_en    (tick_en),
        .init_delay (init_delay_reg),
        .char_delay (char_delay_reg),
        .cmd        (cmd)
    );

    clrs_fbuf u_fbuf (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr_en   (wr_en),
        .wr_pos  (in_pos_reg),
        .wr_char (in_char_reg),
        .rd_idx  (cmd.rd_idx),
        .rd_data (buf_data)
    );

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            init_delay_reg   <= clrs_pkg::INIT_DELAY_RST;
            char_delay_reg   <= clrs_pkg::CHAR_DELAY_RST;
            backlight_on_reg <= 1'b1;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                clrs_pkg::CFG_INIT_DELAY:   init_delay_reg   <= cfg_wdata;
                clrs_pkg::CFG_CHAR_DELAY:   char_delay_reg   <= cfg_wdata;
                clrs_pkg::CFG_BACKLIGHT_ON: backlight_on_reg <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // input stage: hold the word until the result stage can take it
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_mode_reg <= s_tuser;
            in_pos_reg  <= s_tdata[4:0];
            in_char_reg <= s_tdata[12:5];
        end
    end

    // result stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_bl_reg <= backlight_on_reg;
            if (in_mode_reg) begin
                out_xfer_reg <= 1'b0;
                out_rs_reg   <= 1'b0;
                out_byte_reg <= '0;
            end else begin
                out_xfer_reg <= cmd.xfer;
                out_rs_reg   <= cmd.rs;
                out_byte_reg <= cmd.from_buf ? buf_data : cmd.instr;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_rs_reg;
    assign m_tdata  = {6'd0, out_bl_reg, out_byte_reg, out_xfer_reg};

    `CLRS_ASSERT_IMPLY(a_rs_needs_xfer, aclk, aresetn, m_tvalid && !m_tdata[0], !m_tuser)
    `CLRS_ASSERT_NEXT(a_write_is_idle, aclk, aresetn, advance && in_mode_reg, !m_tdata[0])
    `CLRS_ASSERT_NEXT(a_in_word_held, aclk, aresetn, in_valid_reg && !advance, in_valid_reg)

endmodule

// ===== bench/tb_char_lcd_refresh_sequencer_top.sv =====
// Self-checking bench for the LCD refresh sequencer against a predictor.
`timescale 1ns / 1ps

module tb_char_lcd_refresh_sequencer_top;

    typedef struct packed {
        logic                        xfer;
        logic                        rs;
        logic [clrs_pkg::CHAR_W-1:0] data;
        logic                        light;
    } lcd_out_t;

    logic                           aclk = 1'b0;
    logic                           aresetn;
    logic                           s_tvalid;
    logic                           s_tready;
    logic [15:0]                    s_tdata;
    logic                           s_tuser;
    logic                           m_tvalid;
    logic                           m_tready;
    logic [15:0]                    m_tdata;
    logic                           m_tuser;
    logic                           cfg_wr_en;
    logic [clrs_pkg::CFG_AW-1:0]    cfg_addr;
    logic [clrs_pkg::DELAY_W-1:0]   cfg_wdata;

    // predictor copy of the sequencer
    logic [clrs_pkg::PH_W-1:0]      seq_phase;
    logic [3:0]                     step_idx;
    logic [clrs_pkg::DELAY_W-1:0]   wait_left;
    logic [clrs_pkg::CHAR_W-1:0]    frame [clrs_pkg::BUF_SIZE];
    logic [clrs_pkg::DELAY_W-1:0]   init_dly;
    logic [clrs_pkg::DELAY_W-1:0]   char_dly;
    logic                           light_on;

    lcd_out_t                       lcd_expected [$];
    int                             err_count = 0;
    bit                             quiet = 1'b0;

    char_lcd_refresh_sequencer_top dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Load the wait, or step on at once when the delay is zero.
    function automatic void advance_after(logic [clrs_pkg::DELAY_W-1:0] delay,
                                          logic [clrs_pkg::PH_W-1:0] wait_ph);
        logic [4:0] nxt;
        nxt = {1'b0, step_idx} + 5'd1;
        if (delay != '0) begin
            wait_left = delay;
            seq_phase = wait_ph;
        end else begin
            wait_left = '0;
            case (wait_ph)
                clrs_pkg::PH_INIT_WAIT: begin
                    if (nxt >= clrs_pkg::INIT_STEPS) begin
                        step_idx  = '0;
                        seq_phase = clrs_pkg::PH_HOME;
                    end else begin
                        step_idx  = nxt[3:0];
                        seq_phase = clrs_pkg::PH_INIT;
                    end
                end
                clrs_pkg::PH_TOP_WAIT: begin
                    if (nxt >= clrs_pkg::LINE_LENGTH) begin
                        step_idx  = '0;
                        seq_phase = clrs_pkg::PH_LINE2;
                    end else begin
                        step_idx  = nxt[3:0];
                        seq_phase = clrs_pkg::PH_TOP;
                    end
                end
                default: begin
                    if (nxt >= clrs_pkg::LINE_LENGTH) begin
                        step_idx  = '0;
                        seq_phase = clrs_pkg::PH_HOME;
                    end else begin
                        step_idx  = nxt[3:0];
                        seq_phase = clrs_pkg::PH_BOT;
                    end
                end
            endcase
        end
    endfunction

    function automatic lcd_out_t lcd_predict(bit mode, logic [clrs_pkg::POS_W-1:0] pos,
                                             logic [clrs_pkg::CHAR_W-1:0] ch);
        lcd_out_t res;
        res       = '0;
        res.light = light_on;
        if (mode) begin
            if (pos < clrs_pkg::BUF_SIZE)
                frame[pos] = ch;
        end else begin
            case (seq_phase) inside
                clrs_pkg::PH_INIT: begin
                    res.xfer = 1'b1;
                    res.data = clrs_pkg::INIT_SEQ[(step_idx < clrs_pkg::INIT_STEPS) ?
                                                  step_idx : 0];
                    advance_after(init_dly, clrs_pkg::PH_INIT_WAIT);
                end
                clrs_pkg::PH_HOME: begin
                    res.xfer  = 1'b1;
                    res.data  = clrs_pkg::CMD_HOME;
                    step_idx  = '0;
                    seq_phase = clrs_pkg::PH_TOP;
                end
                clrs_pkg::PH_TOP: begin
                    res.xfer = 1'b1;
                    res.rs   = 1'b1;
                    res.data = frame[(step_idx < clrs_pkg::LINE_LENGTH) ? step_idx : 0];
                    advance_after(char_dly, clrs_pkg::PH_TOP_WAIT);
                end
                clrs_pkg::PH_LINE2: begin
                    res.xfer  = 1'b1;
                    res.data  = clrs_pkg::CMD_LINE2;
                    step_idx  = '0;
                    seq_phase = clrs_pkg::PH_BOT;
                end
                clrs_pkg::PH_BOT: begin
                    res.xfer = 1'b1;
                    res.rs   = 1'b1;
                    res.data = frame[clrs_pkg::LINE_LENGTH +
                                     ((step_idx < clrs_pkg::LINE_LENGTH) ? step_idx : 0)];
                    advance_after(char_dly, clrs_pkg::PH_BOT_WAIT);
                end
                clrs_pkg::PH_INIT_WAIT, clrs_pkg::PH_TOP_WAIT, clrs_pkg::PH_BOT_WAIT: begin
                    if (wait_left > clrs_pkg::DELAY_W'(1))
                        wait_left = wait_left - clrs_pkg::DELAY_W'(1);
                    else
                        advance_after('0, seq_phase);
                end
                default: begin
                    step_idx  = '0;
                    wait_left = '0;
                    seq_phase = clrs_pkg::PH_INIT;
                end
            endcase
        end
        return res;
    endfunction

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic send_word(bit mode, logic [clrs_pkg::POS_W-1:0] pos,
                             logic [clrs_pkg::CHAR_W-1:0] ch);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 9);
        if (gap > 0) begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tuser  = mode;
        s_tdata  = {3'b000, ch, pos};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        lcd_expected.push_back(lcd_predict(mode, pos, ch));
        @(negedge aclk);
    endtask

    task automatic send_tick();
        send_word(1'b0, clrs_pkg::POS_W'($urandom_range(0, 31)),
                  clrs_pkg::CHAR_W'($urandom_range(0, 255)));
    endtask

    // Hold off the sender until every word has come back.
    task automatic settle_idle();
        s_tvalid = 1'b0;
        while (lcd_expected.size() != 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    task automatic write_reg(logic [clrs_pkg::CFG_AW-1:0] idx,
                             logic [clrs_pkg::DELAY_W-1:0] val);
        cfg_wr_en = 1'b1;
        cfg_addr  = idx;
        cfg_wdata = val;
        @(negedge aclk);
        cfg_wr_en = 1'b0;
        case (idx)
            clrs_pkg::CFG_INIT_DELAY:   init_dly = val;
            clrs_pkg::CFG_CHAR_DELAY:   char_dly = val;
            clrs_pkg::CFG_BACKLIGHT_ON: light_on = val[0];
            default: ;
        endcase
    endtask

    task automatic check_field(string fname, logic [clrs_pkg::CHAR_W-1:0] want,
                               logic [clrs_pkg::CHAR_W-1:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, fname, want, got);
            err_count++;
        end
    endtask

    // Receiver: random stall per word, check at the accepting edge.
    initial begin
        lcd_out_t want;
        int       stall;
        m_tready = 1'b0;
        @(negedge aclk);
        forever begin
            stall = quiet ? 0 : $urandom_range(0, 9);
            if (stall > 0) begin
                m_tready = 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_tready = 1'b1;
            @(posedge aclk);
            while (!m_tvalid) @(posedge aclk);
            if (lcd_expected.size() == 0) begin
                $display("%0t: unexpected word, expected none, actual %0h/%0h",
                         $time, m_tuser, m_tdata);
                err_count++;
            end else begin
                want = lcd_expected.pop_front();
                check_field("xfer_valid", clrs_pkg::CHAR_W'(want.xfer),
                            clrs_pkg::CHAR_W'(m_tdata[0]));
                check_field("reg_select", clrs_pkg::CHAR_W'(want.rs),
                            clrs_pkg::CHAR_W'(m_tuser));
                check_field("data_byte", want.data, m_tdata[8:1]);
                check_field("backlight", clrs_pkg::CHAR_W'(want.light),
                            clrs_pkg::CHAR_W'(m_tdata[9]));
            end
            @(negedge aclk);
        end
    end

    // Reset values; a wait keeps the 400-tick count even after the delay drops to zero.
    task automatic test_start_and_init_hold();
        send_word(1'b1, 5'd0, 8'hFF);
        send_tick();
        send_tick();
        settle_idle();
        write_reg(clrs_pkg::CFG_INIT_DELAY, 16'd0);
        quiet = 1'b1;
        repeat (400) send_tick();
        repeat (5) send_tick();
        quiet = 1'b0;
        settle_idle();
    endtask

    // Field extremes across a whole frame, writes mixed in without advancing.
    task automatic test_frame_extremes();
        write_reg(clrs_pkg::CFG_CHAR_DELAY, 16'd0);
        send_word(1'b1, 5'd0,  8'h00);
        send_word(1'b1, 5'd15, 8'hFF);
        send_word(1'b1, 5'd16, 8'hFF);
        send_word(1'b1, 5'd31, 8'h00);
        for (int i = 0; i < 2 * clrs_pkg::LINE_LENGTH + 2; i++) begin
            if (i == 10)
                send_word(1'b1, 5'd21, 8'hAA);
            send_tick();
        end
        settle_idle();
    endtask

    // Long character wait with backlight off; it runs out on its loaded count.
    task automatic test_delay_extremes();
        write_reg(clrs_pkg::CFG_INIT_DELAY, 16'hFFFF);
        write_reg(clrs_pkg::CFG_CHAR_DELAY, 16'd300);
        write_reg(clrs_pkg::CFG_BACKLIGHT_ON, 16'd0);
        send_tick();
        while (seq_phase != clrs_pkg::PH_TOP_WAIT && seq_phase != clrs_pkg::PH_BOT_WAIT)
            send_tick();
        settle_idle();
        write_reg(clrs_pkg::CFG_CHAR_DELAY, 16'd2);
        quiet = 1'b1;
        repeat (300 + 4) send_tick();
        quiet = 1'b0;
        settle_idle();
        write_reg(clrs_pkg::CFG_BACKLIGHT_ON, 16'd1);
    endtask

    task automatic test_random_traffic();
        int n;
        for (int p = 0; p < 12; p++) begin
            settle_idle();
            write_reg(clrs_pkg::CFG_INIT_DELAY,
                      clrs_pkg::DELAY_W'($urandom_range(0, 65535)));
            case ($urandom_range(0, 3))
                0: write_reg(clrs_pkg::CFG_CHAR_DELAY, 16'd0);
                1: write_reg(clrs_pkg::CFG_CHAR_DELAY, 16'd1);
                2: write_reg(clrs_pkg::CFG_CHAR_DELAY,
                             clrs_pkg::DELAY_W'($urandom_range(2, 6)));
                default: write_reg(clrs_pkg::CFG_CHAR_DELAY,
                                   clrs_pkg::DELAY_W'($urandom_range(0, 20)));
            endcase
            write_reg(clrs_pkg::CFG_BACKLIGHT_ON,
                      clrs_pkg::DELAY_W'($urandom_range(0, 1)));
            quiet = ($urandom_range(0, 3) == 0);
            n = 90;
            for (int i = 0; i < n; i++) begin
                if (i == n / 2 && $urandom_range(0, 1) == 1)
                    settle_idle();
                if ($urandom_range(0, 3) == 0)
                    send_word(1'b1, clrs_pkg::POS_W'($urandom_range(0, 31)),
                              clrs_pkg::CHAR_W'($urandom_range(0, 255)));
                else
                    send_tick();
            end
            quiet = 1'b0;
        end
    endtask

    initial begin
        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_addr  = '0;
        cfg_wdata = '0;
        seq_phase = clrs_pkg::PH_START;
        step_idx  = '0;
        wait_left = '0;
        init_dly  = clrs_pkg::INIT_DELAY_RST;
        char_dly  = clrs_pkg::CHAR_DELAY_RST;
        light_on  = 1'b1;
        for (int i = 0; i < clrs_pkg::BUF_SIZE; i++)
            frame[i] = clrs_pkg::CHAR_SPACE;
        repeat (8) @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        test_start_and_init_hold();
        test_frame_extremes();
        test_delay_extremes();
        test_random_traffic();

        settle_idle();
        repeat (10) @(negedge aclk);
        if (lcd_expected.size() != 0) begin
            $display("%0t: words missing, expected %0d more, actual 0", $time,
                     lcd_expected.size());
            err_count++;
        end
        if (err_count == 0) begin
            $display("tb_char_lcd_refresh_sequencer_top: done, clean");
        end else begin
            $display("tb_char_lcd_refresh_sequencer_top: done, errors");
        end
        $finish;
    end

    initial begin
        #50_000_000;
        $display("tb_char_lcd_refresh_sequencer_top: done, errors");
        $finish;
    end

endmodule
